[rtl/lfd_pkg.sv]
// Shared constants, widths and controller/datapath interface types for the
// Lagrange fractional decimator. No dependencies.
package lfd_pkg;

   localparam int NUM_POINTS  = 8;
   localparam int SAMPLE_BITS = 16;

   localparam int EFF_POINTS  = NUM_POINTS - (NUM_POINTS % 2);
   localparam int HALF_POINTS = EFF_POINTS / 2;
   localparam int HIST_DEPTH  = EFF_POINTS + 2;
   localparam int HIST_BITS   = $clog2(HIST_DEPTH);
   localparam int IDX_BITS    = $clog2(EFF_POINTS);

   localparam int RATIO_BITS  = 24;
   localparam int FRAC_BITS   = 16;
   localparam int POS_BITS    = FRAC_BITS + 1;
   localparam int SUM_BITS    = RATIO_BITS + 1;
   localparam int CNT_BITS    = SUM_BITS - FRAC_BITS;

   // weight arithmetic
   localparam int WEIGHT_FRAC = 24;
   localparam int W_BITS      = 32;
   localparam int F_BITS      = IDX_BITS + FRAC_BITS + 5;
   localparam int PROD_BITS   = W_BITS + F_BITS;
   localparam int DIV_STEPS   = 8;
   localparam int DIV_CYCLES  = 5;
   localparam int T_BITS      = DIV_STEPS * DIV_CYCLES;
   localparam int DSTEP_BITS  = $clog2(DIV_CYCLES);
   localparam int MAC_BITS    = W_BITS + SAMPLE_BITS;
   localparam int ACC_BITS    = MAC_BITS + IDX_BITS;
   localparam int Y_BITS      = ACC_BITS - WEIGHT_FRAC + 1;

   localparam logic [POS_BITS-1:0] POS_ONE   = POS_BITS'(1) << FRAC_BITS;
   localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(3 * HALF_POINTS);
   localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;
   localparam logic signed [W_BITS-1:0] W_ONE = W_BITS'(1) << WEIGHT_FRAC;

   typedef struct packed {
      logic                shift;
      logic                acc_clear;
      logic                w_init;
      logic                mul;
      logic                div_load;
      logic                div_step;
      logic                w_update;
      logic                mac_mul;
      logic                mac_add;
      logic                finish;
      logic [IDX_BITS-1:0] i_idx;
      logic [IDX_BITS-1:0] j_idx;
   } cmd_type;

   typedef struct packed {
      logic last_input;
      logic out_free;
   } status_type;

endpackage

[rtl/lfd_dpath.sv]
// Datapath: sample history, read position, weight multiplier with small
// divider, multiply-accumulate and output register. Uses lfd_pkg.
module lfd_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  lfd_pkg::cmd_type                    cmd,
   output lfd_pkg::status_type                 status,
   input  logic signed [lfd_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                csr_valid,
   input  logic [lfd_pkg::RATIO_BITS-1:0]      csr_decim_ratio,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lfd_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);
   import lfd_pkg::*;

   logic signed [SAMPLE_BITS-1:0] hist_ff [HIST_DEPTH];
   logic [RATIO_BITS-1:0]         ratio_ff;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic signed [W_BITS-1:0]      w_ff;
   logic signed [PROD_BITS-1:0]   p_ff;
   logic [T_BITS-1:0]             dv_ff, dv_in;
   logic [IDX_BITS-1:0]           rem_ff, rem_in;
   logic                          neg_ff;
   logic signed [MAC_BITS-1:0]    mprod_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, y_in;

   logic [IDX_BITS-1:0]           dsr;
   logic                          den_neg;
   logic signed [F_BITS-1:0]      node, fac;
   logic [PROD_BITS-1:0]          pmag;
   logic [PROD_BITS-1:0]          tsum;
   logic [IDX_BITS:0]             r4;
   logic [HIST_BITS-1:0]          hidx;
   logic [ACC_BITS-1:0]           amag;
   logic [Y_BITS-1:0]             yr;
   logic [RATIO_BITS-1:0]         ratio_eff;
   logic [SUM_BITS-1:0]           sum, csum;
   logic [CNT_BITS-1:0]           cm1;

   assign status.last_input = (cnt_ff <= CNT_BITS'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_data_ff;

   // divisor magnitude and sign of (xi - xj)
   assign den_neg = (cmd.j_idx > cmd.i_idx);
   assign dsr     = den_neg ? (cmd.j_idx - cmd.i_idx) : (cmd.i_idx - cmd.j_idx);

   assign node = F_BITS'($signed({1'b0, cmd.j_idx})) - F_BITS'(HALF_POINTS - 1);
   assign fac  = $signed(F_BITS'(pos_ff)) - (node <<< FRAC_BITS);
   assign hidx = HIST_BITS'(EFF_POINTS + 1) - HIST_BITS'(cmd.i_idx);

   always_comb begin
      pmag = p_ff[PROD_BITS-1] ? (~p_ff + PROD_BITS'(1)) : p_ff;
      tsum = pmag + (PROD_BITS'(dsr) << (FRAC_BITS - 1));
   end

   // eight restoring steps of division by a small divisor per cycle
   always_comb begin
      dv_in  = dv_ff;
      rem_in = rem_ff;
      r4     = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r4    = {rem_in, dv_in[T_BITS-1]};
         dv_in = {dv_in[T_BITS-2:0], 1'b0};
         if (r4 >= {1'b0, dsr}) begin
            r4       = r4 - {1'b0, dsr};
            dv_in[0] = 1'b1;
         end
         rem_in = r4[IDX_BITS-1:0];
      end
   end

   // output rounding and saturation
   always_comb begin
      amag = acc_ff[ACC_BITS-1] ? (~acc_ff + ACC_BITS'(1)) : acc_ff;
      yr   = Y_BITS'((amag + (ACC_BITS'(1) << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC);
      if (acc_ff[ACC_BITS-1]) begin
         if (yr >= (Y_BITS'(1) << (SAMPLE_BITS - 1)))
            y_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         else
            y_in = SAMPLE_BITS'(~yr + Y_BITS'(1));
      end else begin
         if (yr >= (Y_BITS'(1) << (SAMPLE_BITS - 1)))
            y_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         else
            y_in = SAMPLE_BITS'(yr);
      end
   end

   // read position advance
   always_comb begin
      ratio_eff = (ratio_ff < RATIO_ONE) ? RATIO_ONE : ratio_ff;
      sum       = SUM_BITS'(pos_ff) + SUM_BITS'(ratio_eff);
      csum      = (sum + SUM_BITS'(POS_ONE - POS_BITS'(1))) >> FRAC_BITS;
      cm1       = CNT_BITS'(csum) - CNT_BITS'(1);
      pos_in    = POS_BITS'(sum - (SUM_BITS'(cm1) << FRAC_BITS));
      cnt_in    = cnt_ff;
      if (cmd.finish)
         cnt_in = cm1;
      else if (cmd.shift && !status.last_input)
         cnt_in = cnt_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= RATIO_ONE;
         pos_ff       <= POS_ONE;
         cnt_ff       <= CNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid)
            ratio_ff <= csr_decim_ratio;
         cnt_ff <= cnt_in;
         if (cmd.finish) begin
            pos_ff       <= pos_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         hist_ff[0] <= req_sample_in;
         for (int k = 1; k < HIST_DEPTH; k++)
            hist_ff[k] <= hist_ff[k-1];
      end
      if (cmd.w_init)
         w_ff <= W_ONE;
      else if (cmd.w_update)
         w_ff <= neg_ff ? W_BITS'(~dv_ff + T_BITS'(1)) : W_BITS'(dv_ff);
      if (cmd.mul)
         p_ff <= PROD_BITS'(w_ff) * PROD_BITS'(fac);
      if (cmd.div_load) begin
         dv_ff  <= T_BITS'(tsum >> FRAC_BITS);
         rem_ff <= '0;
         neg_ff <= p_ff[PROD_BITS-1] ^ den_neg;
      end else if (cmd.div_step) begin
         dv_ff  <= dv_in;
         rem_ff <= rem_in;
      end
      if (cmd.mac_mul)
         mprod_ff <= MAC_BITS'(w_ff) * MAC_BITS'(hist_ff[hidx]);
      if (cmd.acc_clear)
         acc_ff <= '0;
      else if (cmd.mac_add)
         acc_ff <= acc_ff + ACC_BITS'(mprod_ff);
      if (cmd.finish)
         rsp_data_ff <= y_in;
   end

endmodule

[rtl/lfd_ctrl.sv]
// Controller: sequences weight factors, division steps and accumulation for
// one output. Uses lfd_pkg.
module lfd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output lfd_pkg::cmd_type      cmd,
   input  lfd_pkg::status_type   status
);
   import lfd_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WINIT = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_DLOAD = 4'd3;
   localparam logic [3:0] ST_DSTEP = 4'd4;
   localparam logic [3:0] ST_WUPD  = 4'd5;
   localparam logic [3:0] ST_MACM  = 4'd6;
   localparam logic [3:0] ST_MACA  = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(EFF_POINTS - 1);

   logic [3:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   i_ff, i_in, j_ff, j_in, j_next;
   logic [DSTEP_BITS-1:0] step_ff, step_in;
   logic                  accept, j_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next node, skipping the weight's own node
   always_comb begin
      j_next = j_ff + IDX_BITS'(1);
      if (j_next == i_ff)
         j_next = j_ff + IDX_BITS'(2);
      j_done = (j_ff == IDX_LAST) || ((j_ff == IDX_LAST - IDX_BITS'(1)) && (i_ff == IDX_LAST));
   end

   always_comb begin
      cmd       = '0;
      cmd.i_idx = i_ff;
      cmd.j_idx = j_ff;
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      step_in   = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.shift = 1'b1;
               if (status.last_input) begin
                  cmd.acc_clear = 1'b1;
                  i_in          = '0;
                  state_in      = ST_WINIT;
               end
            end
         end
         ST_WINIT: begin
            cmd.w_init = 1'b1;
            j_in       = (i_ff == '0) ? IDX_BITS'(1) : '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + DSTEP_BITS'(1);
            if (step_ff == DSTEP_BITS'(DIV_CYCLES - 1))
               state_in = ST_WUPD;
         end
         ST_WUPD: begin
            cmd.w_update = 1'b1;
            if (j_done) begin
               state_in = ST_MACM;
            end else begin
               j_in     = j_next;
               state_in = ST_MUL;
            end
         end
         ST_MACM: begin
            cmd.mac_mul = 1'b1;
            state_in    = ST_MACA;
         end
         ST_MACA: begin
            cmd.mac_add = 1'b1;
            if (i_ff == IDX_LAST) begin
               state_in = ST_FIN;
            end else begin
               i_in     = i_ff + IDX_BITS'(1);
               state_in = ST_WINIT;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         step_ff  <= step_in;
      end
   end

endmodule

[rtl/lagrange_fractional_decimator.sv]
// Top level of the Lagrange fractional decimator: joins controller and
// datapath. Depends on lfd_pkg, lfd_ctrl and lfd_dpath.
//
// Usage:
//  req_*  : input samples (signed Q1.15), valid/ready transfer.
//  rsp_*  : interpolated output samples (signed Q1.15, saturated).
//  csr_*  : decimation ratio, unsigned 8.16, input samples per output;
//           csr_ready is always high; write only while the block is idle.
//  Timing: a sample that yields no output is taken and req_ready
//  stays high. A sample that yields an output occupies the single
//  shared weight multiplier and small divider: 8 weights of 7
//  factors, each factor a multiply, a divider load, divide steps of
//  8 quotient bits and an update, plus per weight an init, a multiply
//  and an accumulate, and a finishing step. No sample is taken
//  meanwhile; rsp_valid rises as req_ready returns high.
//  A stalled receiver holds rsp_valid and the data; further samples are
//  still taken while the result waits, and a following output waits in
//  its finishing step until the output register is free.
//  Reset (synchronous): ratio 1.0, read offset 1.0, first output after
//  12 samples, rsp_valid low. History contents are undefined until filled.
module lagrange_fractional_decimator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [lfd_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [lfd_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lfd_pkg::RATIO_BITS-1:0]         csr_decim_ratio
);
   import lfd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lfd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample_in   (req_sample_in),
      .csr_valid       (csr_valid),
      .csr_decim_ratio (csr_decim_ratio),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out)
   );

endmodule

[rtl/lfd_checker.sv]
// Port-level checks for the Lagrange fractional decimator, bound to the top
// level. Depends on lfd_pkg.
module lfd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [lfd_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);
   import lfd_pkg::*;

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed");

   // a new result only ends a computation, during which no sample is taken
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without computation");

   // the computation spans more than the finishing step
   a_rsp_busy_long: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready, 2))
      else $error("result appeared too early");

endmodule

bind lagrange_fractional_decimator lfd_checker u_lfd_checker (.*);

[sim/lagrange_fractional_decimator_tb.sv]
// Self-checking testbench for the Lagrange fractional decimator: predicts each output
// sample in fixed point and compares it with the block's output stream.
// Depends on lfd_pkg and lagrange_fractional_decimator.
module lagrange_fractional_decimator_tb;
   import lfd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 600;
   localparam longint PART_CLAMP  = 64'sd1 << 38;
   localparam longint FINAL_CLAMP = 64'sd1 << 28;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [RATIO_BITS-1:0]         csr_decim_ratio;

   logic signed [SAMPLE_BITS-1:0] pending_samples[$];
   logic signed [SAMPLE_BITS-1:0] expected_samples[$];

   // predictor state
   longint      hist[HIST_DEPTH] = '{default: 0};
   int unsigned frac_pos = 65536;
   int unsigned samples_left = 3 * HALF_POINTS;
   int unsigned ratio_now;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_reqs;
   int hold_done;
   int hold_left;
   int errors = 0;
   int cycles = 0;

   lagrange_fractional_decimator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_decim_ratio (csr_decim_ratio)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint div_nearest(longint num, longint den);
      longint an;
      longint ad;
      longint q;
      bit     neg;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = (an + ad / 2) / ad;
      return neg ? -q : q;
   endfunction

   function automatic longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // shift in one sample; push the interpolated output when one falls due
   task automatic interpolate_sample(input logic signed [SAMPLE_BITS-1:0] s);
      longint      w;
      longint      acc;
      longint      y;
      longint      xi;
      longint      xj;
      int unsigned sum;
      int unsigned c;
      for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = s;
      if (samples_left > 1) begin
         samples_left--;
         return;
      end
      acc = 0;
      for (int i = 0; i < EFF_POINTS; i++) begin
         xi = i - (HALF_POINTS - 1);
         w  = 64'sd1 << WEIGHT_FRAC;
         for (int j = 0; j < EFF_POINTS; j++) begin
            xj = j - (HALF_POINTS - 1);
            if (j != i) begin
               w = div_nearest(w * (longint'(frac_pos) - xj * 65536), (xi - xj) * 65536);
               w = clamp_mag(w, PART_CLAMP);
            end
         end
         w   = clamp_mag(w, FINAL_CLAMP);
         acc += w * hist[EFF_POINTS + 1 - i];
      end
      y = div_nearest(acc, 64'sd1 << WEIGHT_FRAC);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      expected_samples.push_back(SAMPLE_BITS'(y));
      sum          = frac_pos + ((ratio_now < 65536) ? 65536 : ratio_now);
      c            = (sum + 65535) >> 16;
      frac_pos     = sum - (c - 1) * 65536;
      samples_left = c - 1;
   endtask

   // driver: offer queued samples, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_sample_in <= '0;
      end else begin
         if (req_valid && req_ready) interpolate_sample(req_sample_in);
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_sample_in <= pending_samples.pop_front();
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each output transfer against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_done <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected output sample_out=%0d", rsp_sample_out);
               errors++;
            end else begin
               if (rsp_sample_out !== expected_samples[0]) begin
                  $error("sample_out expected %0d actual %0d",
                         expected_samples[0], rsp_sample_out);
                  errors++;
               end
               void'(expected_samples.pop_front());
            end
         end
         if (hold_reqs != hold_done) begin
            hold_done <= hold_done + 1;
            hold_left <= 3000;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_ratio(input int unsigned value);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_decim_ratio <= value[RATIO_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      ratio_now = value;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned ratio, input int count,
                               input int s_idle, input int r_stall);
      logic signed [SAMPLE_BITS-1:0] s;
      write_ratio(ratio);
      send_idle_pct  = s_idle;
      recv_stall_pct = r_stall;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(5))
            0:       s = 16'sh7FFF;
            1:       s = -16'sh8000;
            2:       s = SAMPLE_BITS'($urandom_range(2000)) - 16'sd1000;
            default: s = SAMPLE_BITS'($urandom);
         endcase
         pending_samples.push_back(s);
      end
      wait_drained();
   endtask

   initial begin
      logic signed [SAMPLE_BITS-1:0] directed[$];
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_decim_ratio = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_reqs       = 0;
      ratio_now       = 65536;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, a step, and alternation that overshoots into saturation
      directed = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFF, 16'sh7FFF,
                   16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000, 16'sd0, 16'sh5555,
                   -16'sh5556, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
                   -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001};
      foreach (directed[k]) pending_samples.push_back(directed[k]);
      wait_drained();

      random_phase(32'h010000, 80, 0, 0);
      random_phase(32'h018000, 80, 87, 0);
      random_phase($urandom_range(65536, 262143), 80, 0, 87);
      random_phase($urandom_range(65536, 262143), 80, 37, 37);
      random_phase(32'h01FFFF, 50, 0, 0);

      // long receiver hold-off while samples keep coming: the block must stall its input
      write_ratio(32'h010000);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_reqs      = hold_reqs + 1;
      for (int k = 0; k < 60; k++) pending_samples.push_back(SAMPLE_BITS'($urandom));
      wait_drained();

      random_phase(32'hFFFFFF, 100, 0, 0);
      random_phase(32'h010001, 40, 37, 37);

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
